// ===== rtl/core/sorted_point_table_lookup_core_defines.svh =====
// Assertion macros shared by the sorted point table lookup RTL.
`ifndef SORTED_POINT_TABLE_LOOKUP_CORE_DEFINES_SVH
`define SORTED_POINT_TABLE_LOOKUP_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge outside reset.
`define SPTL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define SPTL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPTL_ASSERT_IMP(label, ante, cons, msg)
`define SPTL_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/core/sptl_pkg.sv =====
// Package with the types and constants of the sorted point table lookup.
package sptl_pkg;

    // Table geometry and field widths.
    localparam int POINT_DEPTH = 1024;
    localparam int COORD_W     = 32;
    localparam int IDX_W       = 10;
    localparam int ADDR_W      = $clog2(POINT_DEPTH);
    localparam int ENTRY_W     = 3 * COORD_W;
    localparam int PTR_W       = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 2;
    localparam int CFG_IDX_W   = 1;

    // Stream payload widths, rounded up to whole bytes.
    localparam int IN_TDATA_W  = ((IDX_W + 3 * COORD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((IDX_W + 7) / 8) * 8;

    // Input item kinds carried on tuser.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_INDEX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX  = 1'b1;

    // Configuration reset values.
    localparam logic [IDX_W-1:0] FIRST_INDEX_RST = '0;
    localparam logic [IDX_W-1:0] LAST_INDEX_RST  = '1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_WLO,
        ST_WLO_CMP,
        ST_WHI,
        ST_WHI_CMP,
        ST_FINISH
    } state_t;

    // Coordinate column currently searched.
    typedef enum logic [1:0] {
        COL_X,
        COL_Y,
        COL_Z
    } col_t;

endpackage

// ===== rtl/core/sptl_ram.sv =====
// Generic single-port RAM with registered read data.
module sptl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One access per cycle: write or read at addr.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/core/sorted_point_table_lookup_core.sv =====
// Top level of the sorted point table lookup: table, search sequencer, output stage.
//
// Usage: a table of 3D points, sorted by x, then y, then z, is loaded through
// the slave stream (tuser = 0, one point per item at entry_index). A query item
// (tuser = 1) searches the index window set by the configuration channel
// (register 0 first_index, register 1 last_index) and returns one item on the
// master stream: found in tuser, match_index in tdata. Loads return nothing.
// A load leaves the block idle, so it is ready for the next item at once.
// A query passes through a probe and a compare state for each binary-search
// probe and through a pair of states for each entry visited while widening the
// x run and the y run, plus the finish state. The single port of the table
// memory allows one table read in flight at a time, and the shared comparator
// checks it in the following cycle. s_tready is low while a
// query is searched. The finished result sits in an output register, so a new
// item is accepted while it waits; a query that finishes while the previous
// result is still held stalls until m_tready takes it. Reset empties the
// output register and restores first_index = 0 and last_index = 1023; table
// contents are not cleared and must be loaded before they are searched.
`include "sorted_point_table_lookup_core_defines.svh"

module sorted_point_table_lookup_core (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input items.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: entry_index, coord_x, coord_y, coord_z, zero padding.
    input  logic [sptl_pkg::IN_TDATA_W-1:0]  s_tdata,
    // s_tuser: func.
    input  logic [0:0]                       s_tuser,
    // Result items.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: match_index, zero padding.
    output logic [sptl_pkg::OUT_TDATA_W-1:0] m_tdata,
    // m_tuser: found.
    output logic [0:0]                       m_tuser,
    // Configuration writes.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sptl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sptl_pkg::IDX_W-1:0]       cfg_data
);

    import sptl_pkg::*;

    localparam logic signed [PTR_W-1:0] PTR_ONE   = PTR_W'(1);
    localparam logic [31:0]             DEPTH_MAX = 32'(POINT_DEPTH - 1);

    // Input field split.
    logic                      in_func;
    logic [IDX_W-1:0]          in_entry_index;
    logic signed [COORD_W-1:0] in_coord_x;
    logic signed [COORD_W-1:0] in_coord_y;
    logic signed [COORD_W-1:0] in_coord_z;

    assign in_func        = s_tuser[0];
    assign in_entry_index = s_tdata[IDX_W-1:0];
    assign in_coord_x     = s_tdata[IDX_W +: COORD_W];
    assign in_coord_y     = s_tdata[IDX_W + COORD_W +: COORD_W];
    assign in_coord_z     = s_tdata[IDX_W + 2 * COORD_W +: COORD_W];

    // Registers.
    state_t                    state_reg, state_next;
    col_t                      col_reg, col_next;
    logic [IDX_W-1:0]          first_index_reg;
    logic [IDX_W-1:0]          last_index_reg;
    logic signed [COORD_W-1:0] key_x_reg, key_x_next;
    logic signed [COORD_W-1:0] key_y_reg, key_y_next;
    logic signed [COORD_W-1:0] key_z_reg, key_z_next;
    logic signed [PTR_W-1:0]   lo_reg, lo_next;
    logic signed [PTR_W-1:0]   hi_reg, hi_next;
    logic signed [PTR_W-1:0]   mid_reg, mid_next;
    // Full range of the column being searched; it bounds the run widening.
    logic signed [PTR_W-1:0]   span_lo_reg, span_lo_next;
    logic signed [PTR_W-1:0]   span_hi_reg, span_hi_next;
    logic signed [PTR_W-1:0]   run_lo_reg, run_lo_next;
    logic signed [PTR_W-1:0]   run_hi_reg, run_hi_next;
    logic                      res_found_reg, res_found_next;
    logic [IDX_W-1:0]          res_index_reg, res_index_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      out_found_reg, out_found_next;
    logic [IDX_W-1:0]          out_index_reg, out_index_next;

    // Table memory signals.
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_addr;
    logic [ENTRY_W-1:0]        ram_wdata;
    logic [ENTRY_W-1:0]        ram_rdata;

    // Shared comparator signals.
    logic signed [COORD_W-1:0] cmp_data;
    logic signed [COORD_W-1:0] cmp_key;
    logic                      cmp_eq;
    logic                      cmp_lt;
    logic signed [PTR_W-1:0]   mid_calc;
    logic signed [PTR_W-1:0]   win_hi;
    logic                      in_accept;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_found_reg;
    assign m_tdata   = OUT_TDATA_W'(out_index_reg);

    // Search window upper bound, clamped to the table.
    assign win_hi = (32'(last_index_reg) > DEPTH_MAX) ? PTR_W'(DEPTH_MAX)
                                                      : PTR_W'(last_index_reg);

    // Middle of the current range.
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >>> 1);

    // Table storage: x in the low bits, then y, then z.
    assign ram_wdata = {in_coord_z, in_coord_y, in_coord_x};

    sptl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (POINT_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Shared comparator: selected column of the read entry against its key.
    always_comb
    begin
        case (col_reg)
            COL_X:
            begin
                cmp_data = ram_rdata[0 +: COORD_W];
                cmp_key  = key_x_reg;
            end
            COL_Y:
            begin
                cmp_data = ram_rdata[COORD_W +: COORD_W];
                cmp_key  = key_y_reg;
            end
            COL_Z:
            begin
                cmp_data = ram_rdata[2 * COORD_W +: COORD_W];
                cmp_key  = key_z_reg;
            end
            default:
            begin
                cmp_data = ram_rdata[0 +: COORD_W];
                cmp_key  = key_x_reg;
            end
        endcase
    end

    assign cmp_eq = (cmp_data == cmp_key);
    assign cmp_lt = (cmp_data < cmp_key);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_index_reg <= FIRST_INDEX_RST;
            last_index_reg  <= LAST_INDEX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FIRST_INDEX: first_index_reg <= cfg_data;
                CFG_LAST_INDEX:  last_index_reg  <= cfg_data;
                default:         first_index_reg <= first_index_reg;
            endcase
        end
    end

    // Sequencer and output state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Search payload registers.
    always_ff @(posedge clk)
    begin
        col_reg       <= col_next;
        key_x_reg     <= key_x_next;
        key_y_reg     <= key_y_next;
        key_z_reg     <= key_z_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        span_lo_reg   <= span_lo_next;
        span_hi_reg   <= span_hi_next;
        run_lo_reg    <= run_lo_next;
        run_hi_reg    <= run_hi_next;
        res_found_reg <= res_found_next;
        res_index_reg <= res_index_next;
        out_found_reg <= out_found_next;
        out_index_reg <= out_index_next;
    end

    // Next state, memory access and result handling.
    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        key_x_next     = key_x_reg;
        key_y_next     = key_y_reg;
        key_z_next     = key_z_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        span_lo_next   = span_lo_reg;
        span_hi_next   = span_hi_reg;
        run_lo_next    = run_lo_reg;
        run_hi_next    = run_hi_reg;
        res_found_next = res_found_reg;
        res_index_next = res_index_reg;
        out_found_next = out_found_reg;
        out_index_next = out_index_reg;
        out_valid_next = out_valid_reg && !m_tready;
        ram_we         = 1'b0;
        ram_addr       = ADDR_W'(in_entry_index);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_func == FUNC_LOAD)
                    begin
                        // A load outside the table is dropped.
                        ram_we = (32'(in_entry_index) < 32'(POINT_DEPTH));
                    end
                    else
                    begin
                        key_x_next     = in_coord_x;
                        key_y_next     = in_coord_y;
                        key_z_next     = in_coord_z;
                        col_next       = COL_X;
                        lo_next        = PTR_W'(first_index_reg);
                        hi_next        = win_hi;
                        span_lo_next   = PTR_W'(first_index_reg);
                        span_hi_next   = win_hi;
                        res_found_next = 1'b0;
                        res_index_next = '0;
                        state_next     = ST_PROBE;
                    end
                end
            end

            ST_PROBE:
            begin
                // An empty range ends the search without a match.
                if (lo_reg > hi_reg)
                begin
                    res_found_next = 1'b0;
                    res_index_next = '0;
                    state_next     = ST_FINISH;
                end
                else
                begin
                    ram_addr   = mid_calc[ADDR_W-1:0];
                    mid_next   = mid_calc;
                    state_next = ST_CMP;
                end
            end

            ST_CMP:
            begin
                ram_addr = mid_reg[ADDR_W-1:0];
                if (cmp_eq)
                begin
                    if (col_reg == COL_Z)
                    begin
                        res_found_next = 1'b1;
                        res_index_next = IDX_W'(mid_reg);
                        state_next     = ST_FINISH;
                    end
                    else
                    begin
                        run_lo_next = mid_reg;
                        run_hi_next = mid_reg;
                        state_next  = ST_WLO;
                    end
                end
                else if (cmp_lt)
                begin
                    lo_next    = mid_reg + PTR_ONE;
                    state_next = ST_PROBE;
                end
                else
                begin
                    hi_next    = mid_reg - PTR_ONE;
                    state_next = ST_PROBE;
                end
            end

            ST_WLO:
            begin
                // Extend the run downward while the entry below matches.
                if (run_lo_reg > span_lo_reg)
                begin
                    ram_addr   = ADDR_W'(run_lo_reg - PTR_ONE);
                    state_next = ST_WLO_CMP;
                end
                else
                begin
                    state_next = ST_WHI;
                end
            end

            ST_WLO_CMP:
            begin
                if (cmp_eq)
                begin
                    run_lo_next = run_lo_reg - PTR_ONE;
                    state_next  = ST_WLO;
                end
                else
                begin
                    state_next = ST_WHI;
                end
            end

            ST_WHI:
            begin
                // Extend the run upward, then search the next column inside it.
                if (run_hi_reg < span_hi_reg)
                begin
                    ram_addr   = ADDR_W'(run_hi_reg + PTR_ONE);
                    state_next = ST_WHI_CMP;
                end
                else
                begin
                    lo_next      = run_lo_reg;
                    hi_next      = run_hi_reg;
                    span_lo_next = run_lo_reg;
                    span_hi_next = run_hi_reg;
                    col_next     = (col_reg == COL_X) ? COL_Y : COL_Z;
                    state_next   = ST_PROBE;
                end
            end

            ST_WHI_CMP:
            begin
                if (cmp_eq)
                begin
                    run_hi_next = run_hi_reg + PTR_ONE;
                    state_next  = ST_WHI;
                end
                else
                begin
                    lo_next      = run_lo_reg;
                    hi_next      = run_hi_reg;
                    span_lo_next = run_lo_reg;
                    span_hi_next = run_hi_reg;
                    col_next     = (col_reg == COL_X) ? COL_Y : COL_Z;
                    state_next   = ST_PROBE;
                end
            end

            ST_FINISH:
            begin
                // Hand the result over once the output register is free.
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_index_next = res_index_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Checks on the search and the output stage.
    `SPTL_ASSERT_IMP(a_probe_in_range, state_reg == ST_CMP, (mid_reg >= lo_reg) && (mid_reg <= hi_reg), "probe outside search range")
    `SPTL_ASSERT_IMP(a_run_in_range, (state_reg == ST_WLO) || (state_reg == ST_WHI), (run_lo_reg >= span_lo_reg) && (run_hi_reg <= span_hi_reg), "run widened past range")
    `SPTL_ASSERT_IMP(a_miss_index_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "miss with nonzero index")
    `SPTL_ASSERT_NXT(a_finish_delivers, (state_reg == ST_FINISH) && (!out_valid_reg || m_tready), m_tvalid && (state_reg == ST_IDLE), "finished result not presented")

endmodule

// ===== sim/tb_sorted_point_table_lookup_core.sv =====
// Self-checking testbench for the sorted point table lookup core.
`timescale 1ns / 100ps

// Tracks the point table and the search window, and predicts each query answer.
class point_lookup_scoreboard;
    logic signed [sptl_pkg::COORD_W-1:0] pt_x [sptl_pkg::POINT_DEPTH];
    logic signed [sptl_pkg::COORD_W-1:0] pt_y [sptl_pkg::POINT_DEPTH];
    logic signed [sptl_pkg::COORD_W-1:0] pt_z [sptl_pkg::POINT_DEPTH];
    logic [sptl_pkg::IDX_W-1:0]          first_idx;
    logic [sptl_pkg::IDX_W-1:0]          last_idx;
    // Each entry holds {found, match_index} of one query still owed by the block.
    logic [sptl_pkg::IDX_W:0]            pending_answers [$];
    int                                  mismatches;

    function new();
        first_idx  = sptl_pkg::FIRST_INDEX_RST;
        last_idx   = sptl_pkg::LAST_INDEX_RST;
        mismatches = 0;
    endfunction

    function logic signed [sptl_pkg::COORD_W-1:0] coord_of(int idx, sptl_pkg::col_t col);
        case (col)
            sptl_pkg::COL_X: coord_of = pt_x[idx];
            sptl_pkg::COL_Y: coord_of = pt_y[idx];
            default:         coord_of = pt_z[idx];
        endcase
    endfunction

    // Binary search of one column over [lo, hi]; -1 when the key is absent.
    function int bisect_column(int lo, int hi, sptl_pkg::col_t col,
                               logic signed [sptl_pkg::COORD_W-1:0] key);
        int mid;
        bisect_column = -1;
        while (lo <= hi && bisect_column < 0)
        begin
            mid = lo + (hi - lo) / 2;
            if (coord_of(mid, col) == key)
                bisect_column = mid;
            else if (coord_of(mid, col) < key)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
    endfunction

    // Grow a hit to the run of equal values in one column, bounded by [lo, hi].
    function void widen_run(int pos, int lo, int hi, sptl_pkg::col_t col,
                            output int run_lo, output int run_hi);
        run_lo = pos;
        run_hi = pos;
        while (run_lo > lo && coord_of(run_lo - 1, col) == coord_of(pos, col))
            run_lo--;
        while (run_hi < hi && coord_of(run_hi + 1, col) == coord_of(pos, col))
            run_hi++;
    endfunction

    // Narrow on x, then y inside the x run, then z inside the y run.
    function logic [sptl_pkg::IDX_W:0] locate_point(logic signed [sptl_pkg::COORD_W-1:0] x,
                                                    logic signed [sptl_pkg::COORD_W-1:0] y,
                                                    logic signed [sptl_pkg::COORD_W-1:0] z);
        int lo;
        int hi;
        int hit;
        int xl;
        int xh;
        int yl;
        int yh;
        locate_point = '0;
        lo = int'(first_idx);
        hi = int'(last_idx);
        if (hi > sptl_pkg::POINT_DEPTH - 1)
            hi = sptl_pkg::POINT_DEPTH - 1;
        if (lo <= hi)
        begin
            hit = bisect_column(lo, hi, sptl_pkg::COL_X, x);
            if (hit >= 0)
            begin
                widen_run(hit, lo, hi, sptl_pkg::COL_X, xl, xh);
                hit = bisect_column(xl, xh, sptl_pkg::COL_Y, y);
                if (hit >= 0)
                begin
                    widen_run(hit, xl, xh, sptl_pkg::COL_Y, yl, yh);
                    hit = bisect_column(yl, yh, sptl_pkg::COL_Z, z);
                    if (hit >= 0)
                        locate_point = {1'b1, hit[sptl_pkg::IDX_W-1:0]};
                end
            end
        end
    endfunction

    function void set_reg(logic [sptl_pkg::CFG_IDX_W-1:0] reg_idx,
                          logic [sptl_pkg::IDX_W-1:0] value);
        if (reg_idx == sptl_pkg::CFG_FIRST_INDEX)
            first_idx = value;
        else if (reg_idx == sptl_pkg::CFG_LAST_INDEX)
            last_idx = value;
    endfunction

    // A load updates the table; a query queues its predicted answer.
    function void note_input(logic func, logic [sptl_pkg::IDX_W-1:0] entry,
                             logic signed [sptl_pkg::COORD_W-1:0] x,
                             logic signed [sptl_pkg::COORD_W-1:0] y,
                             logic signed [sptl_pkg::COORD_W-1:0] z);
        if (func == sptl_pkg::FUNC_LOAD)
        begin
            if (int'(entry) < sptl_pkg::POINT_DEPTH)
            begin
                pt_x[entry] = x;
                pt_y[entry] = y;
                pt_z[entry] = z;
            end
        end
        else
        begin
            pending_answers.push_back(locate_point(x, y, z));
        end
    endfunction

    function void check_result(logic found, logic [sptl_pkg::IDX_W-1:0] match_index);
        logic [sptl_pkg::IDX_W:0] answer;
        if (pending_answers.size() == 0)
        begin
            $error("result item with no query waiting: found %0d match_index %0d",
                   found, match_index);
            mismatches++;
        end
        else
        begin
            answer = pending_answers.pop_front();
            if (found !== answer[sptl_pkg::IDX_W])
            begin
                $error("found: expected %0d, actual %0d", answer[sptl_pkg::IDX_W], found);
                mismatches++;
            end
            if (match_index !== answer[sptl_pkg::IDX_W-1:0])
            begin
                $error("match_index: expected %0d, actual %0d",
                       answer[sptl_pkg::IDX_W-1:0], match_index);
                mismatches++;
            end
        end
    endfunction
endclass

module tb_sorted_point_table_lookup_core;
    import sptl_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 12;
    // Covers the longest query on the tables built here, plus the longest
    // stall on either side, with a wide margin.
    localparam int WATCHDOG_LIMIT = 20000;
    // A load can still be in flight when the last answer arrives.
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 64;
    localparam int NUM_PHASES     = 12;
    localparam int PHASE_ITEMS    = 80;

    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [0:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [IDX_W-1:0]       cfg_data  = '0;

    point_lookup_scoreboard sb;
    bit                     idling_on = 1'b1;
    int                     win_lo;
    int                     win_hi;

    always #CLK_HALF clk = ~clk;

    sorted_point_table_lookup_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Present one item and hold it until accepted, then maybe idle for a burst.
    task automatic send_item(input logic func, input int entry,
                             input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic signed [COORD_W-1:0] z);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[IDX_W-1:0]                 = entry[IDX_W-1:0];
        word[IDX_W +: COORD_W]             = x;
        word[IDX_W + COORD_W +: COORD_W]   = y;
        word[IDX_W + 2*COORD_W +: COORD_W] = z;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= word;
        do @(posedge clk); while (!s_tready);
        sb.note_input(func, entry[IDX_W-1:0], x, y, z);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every predicted answer has been returned.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] reg_idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= reg_idx;
        cfg_data  <= value[IDX_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(reg_idx, value[IDX_W-1:0]);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_window(input int lo, input int hi);
        wait_results_drained();
        write_register(CFG_FIRST_INDEX, lo);
        write_register(CFG_LAST_INDEX, hi);
        win_lo = lo;
        win_hi = hi;
    endtask

    function automatic logic signed [COORD_W-1:0] any_coord();
        case ($urandom_range(0, 9))
            0:       any_coord = COORD_MIN;
            1:       any_coord = COORD_MAX;
            2:       any_coord = '0;
            3:       any_coord = '1;
            default: any_coord = $urandom;
        endcase
    endfunction

    // Fill the whole table in x, y, z order with runs of equal x and of equal y.
    task automatic load_sorted_table();
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        int                        pick;
        for (int i = 0; i < POINT_DEPTH; i++)
        begin
            pick = $urandom_range(0, 7);
            if (i == 0 || i == POINT_DEPTH - 1 || pick < 3)
            begin
                // New x: slot i of 4M-wide steps plus jitter, so x keeps rising.
                if (i == 0)
                    px = COORD_MIN;
                else if (i == POINT_DEPTH - 1)
                    px = COORD_MAX;
                else
                    px = ({i[IDX_W-1:0], 22'd0} + $urandom_range(0, 2097151)) ^ COORD_MIN;
                py = $urandom | COORD_MIN;
                pz = $urandom | COORD_MIN;
            end
            else if (pick < 6)
            begin
                py = py + $urandom_range(1, 1048576);
                pz = $urandom | COORD_MIN;
            end
            else
            begin
                pz = pz + $urandom_range(1, 1048576);
            end
            send_item(FUNC_LOAD, i, px, py, pz);
        end
    endtask

    // Rewrite an entry with a new z that keeps the table sorted and distinct.
    task automatic retouch_entry(input int e);
        longint                    lo_z;
        longint                    hi_z;
        logic signed [COORD_W-1:0] nz;
        lo_z = longint'(COORD_MIN);
        hi_z = longint'(COORD_MAX);
        if (e > 0 && sb.pt_x[e-1] == sb.pt_x[e] && sb.pt_y[e-1] == sb.pt_y[e])
            lo_z = longint'(sb.pt_z[e-1]) + 1;
        if (e < POINT_DEPTH - 1 && sb.pt_x[e+1] == sb.pt_x[e] && sb.pt_y[e+1] == sb.pt_y[e])
            hi_z = longint'(sb.pt_z[e+1]) - 1;
        nz = COORD_W'(lo_z + longint'({$urandom, $urandom} % (hi_z - lo_z + 1)));
        send_item(FUNC_LOAD, e, sb.pt_x[e], sb.pt_y[e], nz);
    endtask

    task automatic query_entry(input int e);
        send_item(FUNC_QUERY, $urandom_range(0, POINT_DEPTH - 1),
                  sb.pt_x[e], sb.pt_y[e], sb.pt_z[e]);
    endtask

    // Mostly stored points, plus near misses and fully random coordinates.
    task automatic send_query();
        int e;
        int pick;
        pick = $urandom_range(0, 19);
        if (win_lo <= win_hi && pick < 10)
            e = $urandom_range(win_lo, win_hi);
        else
            e = $urandom_range(0, POINT_DEPTH - 1);
        if (pick < 12)
            query_entry(e);
        else if (pick < 14)
            send_item(FUNC_QUERY, $urandom, sb.pt_x[e], sb.pt_y[e], any_coord());
        else if (pick < 16)
            send_item(FUNC_QUERY, $urandom, sb.pt_x[e], any_coord(), any_coord());
        else if (pick < 17)
            send_item(FUNC_QUERY, $urandom, sb.pt_x[e], sb.pt_y[e], sb.pt_z[e] + 1);
        else
            send_item(FUNC_QUERY, $urandom, any_coord(), any_coord(), any_coord());
    endtask

    task automatic pick_window(output int lo, output int hi);
        int a;
        int b;
        case ($urandom_range(0, 5))
            0:
            begin
                lo = 0;
                hi = POINT_DEPTH - 1;
            end
            1:
            begin
                a  = $urandom_range(0, POINT_DEPTH - 1);
                b  = $urandom_range(0, POINT_DEPTH - 1);
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
            end
            2:
            begin
                lo = $urandom_range(0, POINT_DEPTH - 16);
                hi = lo + $urandom_range(0, 15);
            end
            3:
            begin
                // Empty window: first index above last index.
                lo = $urandom_range(1, POINT_DEPTH - 1);
                hi = $urandom_range(0, lo - 1);
            end
            4:
            begin
                lo = 0;
                hi = $urandom_range(0, POINT_DEPTH - 1);
            end
            default:
            begin
                lo = $urandom_range(0, POINT_DEPTH - 1);
                hi = POINT_DEPTH - 1;
            end
        endcase
    endtask

    // Result side: check each accepted result item and stall in random bursts.
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser[0], m_tdata[IDX_W-1:0]);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run after too many cycles without any handshake.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no item accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_sorted_point_table_lookup_core failed");
        $finish;
    end

    // Main sequence: reset, table load, directed queries, random phases, drain.
    initial
    begin : stimulus
        int pause_at;
        sb     = new();
        win_lo = 0;
        win_hi = POINT_DEPTH - 1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_sorted_table();

        // Directed: ends of the table, extreme coordinates, near misses.
        query_entry(0);
        query_entry(POINT_DEPTH - 1);
        send_item(FUNC_QUERY, 0, COORD_MIN, COORD_MAX, COORD_MAX);
        send_item(FUNC_QUERY, POINT_DEPTH - 1, COORD_MAX, COORD_MIN, COORD_MIN);
        send_item(FUNC_QUERY, 0, '0, '0, '0);
        send_item(FUNC_QUERY, POINT_DEPTH - 1, '1, '1, '1);
        query_entry(511);
        send_item(FUNC_QUERY, 0, sb.pt_x[511], sb.pt_y[511], sb.pt_z[511] + 1);
        // A load followed at once by a query of the rewritten entry.
        retouch_entry(511);
        query_entry(511);

        // Directed windows: single entry, empty, top end, bottom end.
        set_window(5, 5);
        query_entry(5);
        query_entry(6);
        set_window(10, 3);
        query_entry(5);
        set_window(POINT_DEPTH - 1, POINT_DEPTH - 1);
        query_entry(POINT_DEPTH - 1);
        query_entry(POINT_DEPTH - 2);
        set_window(0, 0);
        query_entry(0);
        query_entry(1);

        // Random phases, each with its own window; the last ones run without idling.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            idling_on = (p < NUM_PHASES - 3) && ($urandom_range(0, 3) != 0);
            if (p == NUM_PHASES - 1)
            begin
                set_window(0, POINT_DEPTH - 1);
            end
            else
            begin
                pick_window(win_lo, win_hi);
                set_window(win_lo, win_hi);
            end
            pause_at = $urandom_range(10, PHASE_ITEMS - 10);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Hold the sender until the block has answered everything.
                if (n == pause_at)
                    wait_results_drained();
                if ($urandom_range(0, 6) == 0)
                    retouch_entry($urandom_range(0, POINT_DEPTH - 1));
                else
                    send_query();
            end
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_answers.size() == 0)
            $display("tb_sorted_point_table_lookup_core passed");
        else
            $display("tb_sorted_point_table_lookup_core failed");
        $finish;
    end

endmodule
